FILE: hdl/gfau_pkg.sv
// Package for the binary field arithmetic unit: codes, default sizes and reset values.
// Used by gfau_mul, the top level and the checker. It depends on nothing else.
package gfau_pkg;

    // Default sizes for the top level parameters.
    localparam int unsigned DEF_FIELD_BITS = 320;
    localparam int unsigned DEF_WORDS      = 5;
    localparam int unsigned WORD_W         = 64;
    localparam int unsigned CFG_W          = 9;

    // Request actions.
    localparam logic [1:0] ACT_LOAD_A = 2'd0;
    localparam logic [1:0] ACT_LOAD_B = 2'd1;
    localparam logic [1:0] ACT_RUN    = 2'd2;

    // Operations of a run request.
    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_MUL    = 3'd1;
    localparam logic [2:0] OP_SQUARE = 3'd2;
    localparam logic [2:0] OP_POWER  = 3'd3;
    localparam logic [2:0] OP_TRACE  = 3'd4;
    localparam logic [2:0] OP_REDUCE = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DEGREE   = 2'd0;
    localparam logic [1:0] CFG_TAP_HIGH = 2'd1;
    localparam logic [1:0] CFG_TAP_MID  = 2'd2;
    localparam logic [1:0] CFG_TAP_LOW  = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] RST_DEGREE   = 9'd283;
    localparam logic [CFG_W-1:0] RST_TAP_HIGH = 9'd12;
    localparam logic [CFG_W-1:0] RST_TAP_MID  = 9'd7;
    localparam logic [CFG_W-1:0] RST_TAP_LOW  = 9'd5;

endpackage

FILE: hdl/gfau_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; width and depth come from parameters.
module gfau_ram #(
    parameter int unsigned W = 64,
    parameter int unsigned D = 5
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                          i_wdata,
    input  logic                                  i_re,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                          o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/gfau_mul.sv
// Bit-serial multiply and reduce unit: p = a * b mod P over the low i_n bits of b.
// Depends on gfau_pkg; one coefficient of b is consumed each cycle.
module gfau_mul import gfau_pkg::*; #(
    parameter int unsigned PW = DEF_WORDS * WORD_W,
    parameter int unsigned KW = 9,
    parameter int unsigned MW = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [PW-1:0] i_a,
    input  logic [PW-1:0] i_b,
    input  logic [KW-1:0] i_n,
    input  logic [PW-1:0] i_mod,
    input  logic [MW-1:0] i_m,
    output logic          o_done,
    output logic [PW-1:0] o_p
);
    localparam int unsigned BW = $clog2(PW);

    logic [PW-1:0] r_acc, r_a, r_b;
    logic [PW-1:0] n_acc, shifted;
    logic [KW-1:0] r_cnt, cnt_m1;
    logic          r_busy, r_done;

    // One step: multiply the accumulator by x, reduce, and add a when the bit is set.
    always_comb begin
        cnt_m1  = r_cnt - 1'b1;
        shifted = {r_acc[PW-2:0], 1'b0};
        if (shifted[i_m]) begin
            shifted = shifted ^ i_mod;
        end
        n_acc = r_b[cnt_m1[BW-1:0]] ? (shifted ^ r_a) : shifted;
    end

    // Step counter and accumulator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_n;
            end else if (r_busy) begin
                r_cnt <= cnt_m1;
                if (cnt_m1 == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and accumulator registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
        end else if (r_busy) begin
            r_acc <= n_acc;
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;
endmodule

FILE: hdl/binary_field_arithmetic_unit.sv
// Top level of the binary field arithmetic unit: operand and result memories and sequencer.
// Depends on gfau_pkg, gfau_ram and gfau_mul.
//
// Channel   | Direction | Handshake          | Payload
// request   | in        | i_valid / o_ready  | i_action, i_word_index, i_data_word, i_operation
// result    | out       | o_valid / i_ready  | o_out_index, o_result_word, o_last
// config    | in        | i_cfg_we           | i_cfg_index, i_cfg_data
//
// A run fetches the operands, reduces A (A+B for an addition) and, for a multiply, also B by
// multiplying with one, then multiplies bit-serially in the shared multiply unit: power costs
// up to 2*64*WORDS products, trace m-1 squarings; add and reduce need no further product.
// The result is written to memory; each word is read (S_OUT_RD), then shown (S_OUT_SHOW).
// Reset is synchronous and active low; a stalled result word simply holds.
module binary_field_arithmetic_unit import gfau_pkg::*; #(
    parameter int unsigned FIELD_BITS = DEF_FIELD_BITS,
    parameter int unsigned WORDS      = DEF_WORDS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_action,
    input  logic [2:0]        i_word_index,
    input  logic [WORD_W-1:0] i_data_word,
    input  logic [2:0]        i_operation,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [2:0]        o_out_index,
    output logic [WORD_W-1:0] o_result_word,
    output logic              o_last,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);
    localparam int unsigned PW  = WORD_W * WORDS;
    localparam int unsigned CAP = (FIELD_BITS < PW) ? FIELD_BITS : PW;
    localparam int unsigned MW  = $clog2(CAP);
    localparam int unsigned KW  = $clog2(PW + 1);
    localparam int unsigned BW  = $clog2(PW);
    localparam int unsigned WA  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int unsigned WC  = $clog2(WORDS + 1);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_FETCH    = 12'b0000_0000_0010,
        S_PREP     = 12'b0000_0000_0100,
        S_RED_A    = 12'b0000_0000_1000,
        S_RED_B    = 12'b0000_0001_0000,
        S_MUL      = 12'b0000_0010_0000,
        S_POW_M    = 12'b0000_0100_0000,
        S_POW_S    = 12'b0000_1000_0000,
        S_TRACE    = 12'b0001_0000_0000,
        S_WB       = 12'b0010_0000_0000,
        S_OUT_RD   = 12'b0100_0000_0000,
        S_OUT_SHOW = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_degree, r_tap_high, r_tap_mid, r_tap_low;
    logic [2:0]       r_op, n_op;
    logic [MW-1:0]    r_m, n_m, m_cfg;
    logic [PW-1:0]    r_mod, n_mod, mod_cfg;
    logic [PW-1:0]    r_araw, n_araw, r_braw, n_braw;
    logic [PW-1:0]    r_ra, n_ra, r_t, n_t, r_res, n_res;
    logic [KW-1:0]    r_k, n_k, kn;
    logic [WC-1:0]    r_fw, n_fw, fidx, r_nw, n_nw;
    logic [WA-1:0]    r_oi, n_oi;
    logic [10:0]      fd_ext, m_sat;
    logic [MW:0]      m_round;
    logic [WORDS-1:0] r_a_vld, r_b_vld;

    logic              mstart, mdone;
    logic [PW-1:0]     ma, mb, mp;
    logic [KW-1:0]     mn;
    logic              a_we, b_we, op_re, acc_we, acc_re, idx_ok, last_word;
    logic [WORD_W-1:0] a_rdata, b_rdata, acc_wdata;
    logic [WA-1:0]     op_raddr, acc_waddr;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree   <= RST_DEGREE;
            r_tap_high <= RST_TAP_HIGH;
            r_tap_mid  <= RST_TAP_MID;
            r_tap_low  <= RST_TAP_LOW;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEGREE:   r_degree   <= i_cfg_data;
                CFG_TAP_HIGH: r_tap_high <= i_cfg_data;
                CFG_TAP_MID:  r_tap_mid  <= i_cfg_data;
                CFG_TAP_LOW:  r_tap_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Saturated degree and modulus built from the configuration; sampled at run start.
    always_comb begin
        fd_ext = {2'b00, r_degree};
        if (fd_ext < 11'd2) begin
            m_sat = 11'd2;
        end else if (fd_ext > 11'(CAP - 1)) begin
            m_sat = 11'(CAP - 1);
        end else begin
            m_sat = fd_ext;
        end
        m_cfg          = m_sat[MW-1:0];
        mod_cfg        = '0;
        mod_cfg[m_cfg] = 1'b1;
        mod_cfg[0]     = 1'b1;
        if (r_tap_high != '0 && {2'b00, r_tap_high} < m_sat) begin
            mod_cfg[r_tap_high] = 1'b1;
        end
        if (r_tap_mid != '0 && {2'b00, r_tap_mid} < m_sat) begin
            mod_cfg[r_tap_mid] = 1'b1;
        end
        if (r_tap_low != '0 && {2'b00, r_tap_low} < m_sat) begin
            mod_cfg[r_tap_low] = 1'b1;
        end
    end

    // Operand memory writes happen on accepted load requests whose word index is below WORDS.
    assign o_ready  = (r_state == S_IDLE);
    assign idx_ok   = (5'(i_word_index) < 5'(WORDS));
    assign a_we     = o_ready && i_valid && (i_action == ACT_LOAD_A) && idx_ok;
    assign b_we     = o_ready && i_valid && (i_action == ACT_LOAD_B) && idx_ok;
    assign op_re    = (r_state == S_FETCH) && (r_fw < WC'(WORDS));
    assign op_raddr = r_fw[WA-1:0];

    // Written flags: an operand word not loaded since reset reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= '0;
            r_b_vld <= '0;
        end else begin
            if (a_we) begin
                r_a_vld[i_word_index[WA-1:0]] <= 1'b1;
            end
            if (b_we) begin
                r_b_vld[i_word_index[WA-1:0]] <= 1'b1;
            end
        end
    end

    gfau_ram #(.W(WORD_W), .D(WORDS)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (i_word_index[WA-1:0]),
        .i_wdata (i_data_word),
        .i_re    (op_re),
        .i_raddr (op_raddr),
        .o_rdata (a_rdata)
    );

    gfau_ram #(.W(WORD_W), .D(WORDS)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (i_word_index[WA-1:0]),
        .i_wdata (i_data_word),
        .i_re    (op_re),
        .i_raddr (op_raddr),
        .o_rdata (b_rdata)
    );

    // Result memory: written after the run, read once for each result word shown.
    assign acc_we    = (r_state == S_WB);
    assign acc_waddr = r_fw[WA-1:0];
    assign acc_wdata = r_res[r_fw * WORD_W +: WORD_W];
    assign acc_re    = (r_state == S_OUT_RD);

    gfau_ram #(.W(WORD_W), .D(WORDS)) u_ram_acc (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_waddr (acc_waddr),
        .i_wdata (acc_wdata),
        .i_re    (acc_re),
        .i_raddr (r_oi),
        .o_rdata (o_result_word)
    );

    gfau_mul #(.PW(PW), .KW(KW), .MW(MW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mstart),
        .i_a     (ma),
        .i_b     (mb),
        .i_n     (mn),
        .i_mod   (r_mod),
        .i_m     (r_m),
        .o_done  (mdone),
        .o_p     (mp)
    );

    // Result word handshake.
    assign o_valid     = (r_state == S_OUT_SHOW);
    assign last_word   = ((WC'(r_oi) + 1'b1) == r_nw);
    assign o_last      = last_word;
    assign o_out_index = 3'(r_oi);

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_m     = r_m;
        n_mod   = r_mod;
        n_araw  = r_araw;
        n_braw  = r_braw;
        n_ra    = r_ra;
        n_t     = r_t;
        n_res   = r_res;
        n_k     = r_k;
        n_fw    = r_fw;
        n_nw    = r_nw;
        n_oi    = r_oi;
        mstart  = 1'b0;
        ma      = r_ra;
        mb      = r_ra;
        mn      = KW'(r_m);
        kn      = r_k + 1'b1;
        fidx    = r_fw - 1'b1;
        m_round = {1'b0, r_m} + (MW+1)'(63);
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && i_action == ACT_RUN && i_operation <= OP_REDUCE) begin
                    n_op    = i_operation;
                    n_m     = m_cfg;
                    n_mod   = mod_cfg;
                    n_fw    = '0;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                if (r_fw != '0) begin
                    n_araw[fidx * WORD_W +: WORD_W] = r_a_vld[fidx[WA-1:0]] ? a_rdata : '0;
                    n_braw[fidx * WORD_W +: WORD_W] = r_b_vld[fidx[WA-1:0]] ? b_rdata : '0;
                end
                n_fw = r_fw + 1'b1;
                if (r_fw == WC'(WORDS)) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                // Reduce A, or A+B for an addition, by multiplying with one.
                mstart  = 1'b1;
                ma      = PW'(1);
                mb      = (r_op == OP_ADD) ? (r_araw ^ r_braw) : r_araw;
                mn      = KW'(PW);
                n_fw    = '0;
                n_state = S_RED_A;
            end
            S_RED_A: begin
                if (mdone) begin
                    n_ra = mp;
                    unique case (r_op)
                        OP_MUL: begin
                            mstart  = 1'b1;
                            ma      = PW'(1);
                            mb      = r_braw;
                            mn      = KW'(PW);
                            n_state = S_RED_B;
                        end
                        OP_SQUARE: begin
                            mstart  = 1'b1;
                            ma      = mp;
                            mb      = mp;
                            n_state = S_MUL;
                        end
                        OP_POWER: begin
                            n_t    = PW'(1);
                            n_k    = '0;
                            mstart = 1'b1;
                            if (r_braw[0]) begin
                                ma      = PW'(1);
                                mb      = mp;
                                n_state = S_POW_M;
                            end else begin
                                ma      = mp;
                                mb      = mp;
                                n_state = S_POW_S;
                            end
                        end
                        OP_TRACE: begin
                            n_t     = mp;
                            n_k     = KW'(1);
                            mstart  = 1'b1;
                            ma      = mp;
                            mb      = mp;
                            n_state = S_TRACE;
                        end
                        default: begin
                            n_res   = mp;
                            n_state = S_WB;
                        end
                    endcase
                end
            end
            S_RED_B: begin
                if (mdone) begin
                    mstart  = 1'b1;
                    ma      = r_ra;
                    mb      = mp;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (mdone) begin
                    n_res   = mp;
                    n_state = S_WB;
                end
            end
            S_POW_M: begin
                if (mdone) begin
                    n_t     = mp;
                    mstart  = 1'b1;
                    ma      = r_ra;
                    mb      = r_ra;
                    n_state = S_POW_S;
                end
            end
            S_POW_S: begin
                if (mdone) begin
                    n_ra = mp;
                    n_k  = kn;
                    if (kn == KW'(PW)) begin
                        n_res   = r_t;
                        n_state = S_WB;
                    end else if (r_braw[kn[BW-1:0]]) begin
                        mstart  = 1'b1;
                        ma      = r_t;
                        mb      = mp;
                        n_state = S_POW_M;
                    end else begin
                        mstart  = 1'b1;
                        ma      = mp;
                        mb      = mp;
                        n_state = S_POW_S;
                    end
                end
            end
            S_TRACE: begin
                if (mdone) begin
                    n_ra = mp;
                    n_t  = r_t ^ mp;
                    n_k  = kn;
                    if (kn < KW'(r_m)) begin
                        mstart = 1'b1;
                        ma     = mp;
                        mb     = mp;
                    end else begin
                        n_res   = PW'(r_t[0] ^ mp[0]);
                        n_state = S_WB;
                    end
                end
            end
            S_WB: begin
                n_fw = r_fw + 1'b1;
                if (r_fw == WC'(WORDS - 1)) begin
                    n_oi    = '0;
                    n_nw    = (r_op == OP_TRACE) ? WC'(1) : WC'(m_round >> 6);
                    n_state = S_OUT_RD;
                end
            end
            S_OUT_RD: begin
                n_state = S_OUT_SHOW;
            end
            S_OUT_SHOW: begin
                if (i_ready) begin
                    if (last_word) begin
                        n_state = S_IDLE;
                    end else begin
                        n_oi    = r_oi + 1'b1;
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fw    <= '0;
            r_oi    <= '0;
            r_k     <= '0;
            r_nw    <= '0;
            r_op    <= OP_ADD;
        end else begin
            r_state <= n_state;
            r_fw    <= n_fw;
            r_oi    <= n_oi;
            r_k     <= n_k;
            r_nw    <= n_nw;
            r_op    <= n_op;
        end
    end

    // Working values carry no reset.
    always_ff @(posedge i_clk) begin
        r_m    <= n_m;
        r_mod  <= n_mod;
        r_araw <= n_araw;
        r_braw <= n_braw;
        r_ra   <= n_ra;
        r_t    <= n_t;
        r_res  <= n_res;
    end
endmodule

FILE: hdl/gfau_chk.sv
// Port checker for the binary field arithmetic unit, bound to the top level.
// Depends on gfau_pkg for the word width.
module gfau_chk import gfau_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input logic [2:0]        o_out_index,
    input logic [WORD_W-1:0] o_result_word,
    input logic              o_last
);
    // No result is shown straight after reset.
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // No request is taken while a result word is pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("request taken while a result is pending");

    // A stalled result word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_word)
            && $stable(o_out_index) && $stable(o_last))
        else $error("stalled result changed");

    // After a taken word o_valid drops; the next word, if any, first needs a memory read.
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready |=> !o_valid)
        else $error("result words back to back");

    // The last word returns the unit to accepting requests.
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_last |=> o_ready)
        else $error("unit not idle after last word");
endmodule

bind binary_field_arithmetic_unit gfau_chk u_gfau_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_out_index   (o_out_index),
    .o_result_word (o_result_word),
    .o_last        (o_last)
);
